FILE: rtl/tcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, widths and helpers for the track clone filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int COORD_W        = 24;
    localparam int THRESH_W       = 16;
    localparam int TRACK_IDX_W    = 6;
    localparam int MAX_TRACKS_DEF = 64;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd256;

    // register index taken from paddr[2]
    localparam logic REG_MATCH_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] r;
    } track_t;

    typedef struct packed {
        logic                   valid;
        logic [TRACK_IDX_W-1:0] idx;
    } cmp_tag_t;

    typedef struct packed {
        logic                   valid;
        logic                   close;
        logic [TRACK_IDX_W-1:0] idx;
    } cmp_res_t;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W:0] a,
        input logic signed [COORD_W:0] b
    );
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] nd;
        begin
            d  = a - b;
            nd = -d;
            abs_diff = d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/track_clone_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// track_clone_filter
// Loads a batch of track circles and emits the ones that are not clones.
// ----------------------------------------------------------------------------
// Candidates load at one per cycle while in_ready is high, into a
// MAX_TRACKS-entry table; extra ones are dropped. The transaction with
// last_track set starts filtering: every pair i<j of the n held entries is
// compared through a single comparator fed by the table's two read ports,
// one pair per cycle, then the compare pipeline drains. A downward scan for
// the last survivor follows, then survivors are emitted in load order,
// skipping clones and stalling while out_ready is low. New input is taken
// once the final survivor sits in the output register.
// ----------------------------------------------------------------------------
module track_clone_filter #(
    parameter int MAX_TRACKS = tcf_pkg::MAX_TRACKS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tcf_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [tcf_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [tcf_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [tcf_pkg::COORD_W-1:0]   center_x,
    input  wire logic signed [tcf_pkg::COORD_W-1:0]   center_y,
    input  wire logic        [tcf_pkg::COORD_W-1:0]   radius,
    input  wire logic                                 last_track,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic        [tcf_pkg::TRACK_IDX_W-1:0]    track_index,
    output logic signed [tcf_pkg::COORD_W-1:0]        out_center_x,
    output logic signed [tcf_pkg::COORD_W-1:0]        out_center_y,
    output logic        [tcf_pkg::COORD_W-1:0]        out_radius,
    output logic                                      run_end
);

    localparam int IDX_W = $clog2(MAX_TRACKS);
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRACKS);

    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_CMP       = 3'd1;
    localparam logic [2:0] ST_DRAIN     = 3'd2;
    localparam logic [2:0] ST_LAST      = 3'd3;
    localparam logic [2:0] ST_EMIT_RD   = 3'd4;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                n_reg, n_next;
    logic [IDX_W-1:0]                i_reg, i_next;
    logic [IDX_W-1:0]                j_reg, j_next;
    logic [IDX_W-1:0]                s_reg, s_next;
    logic [IDX_W-1:0]                last_reg, last_next;
    logic [MAX_TRACKS-1:0]           keep_reg, keep_next;
    logic                            v1_reg;
    logic [IDX_W-1:0]                j1_reg;
    logic [tcf_pkg::THRESH_W-1:0]    thresh_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]                out_idx_reg, out_idx_next;
    tcf_pkg::track_t                 out_data_reg, out_data_next;
    logic                            out_end_reg, out_end_next;

    logic                            in_fire;
    logic                            room;
    logic                            mem_we;
    tcf_pkg::track_t                 mem_wdata;
    logic [IDX_W-1:0]                raddr_a;
    tcf_pkg::track_t                 rdata_a;
    tcf_pkg::track_t                 rdata_b;
    tcf_pkg::cmp_tag_t               cmp_tag;
    tcf_pkg::cmp_res_t               cmp_res;
    logic                            last_j;
    logic                            last_i;
    logic [CNT_W-1:0]                n_minus1;
    logic                            cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tcf_pkg::REG_MATCH_THRESHOLD);
    assign prdata = (paddr[2] == tcf_pkg::REG_MATCH_THRESHOLD)
                    ? tcf_pkg::APB_DATA_W'(thresh_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= tcf_pkg::THRESH_RESET;
        end
        else if (cfg_wr)
        begin
            thresh_reg <= pwdata[tcf_pkg::THRESH_W-1:0];
        end
    end

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign room      = (count_reg < MAX_CNT);
    assign mem_we    = in_fire && room;
    assign mem_wdata = '{x: center_x, y: center_y, r: radius};
    assign raddr_a   = (state_reg == ST_CMP) ? i_reg : s_reg;

    tcf_track_mem #(
        .DEPTH (MAX_TRACKS),
        .ADDR_W(IDX_W)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (count_reg[IDX_W-1:0]),
        .wdata  (mem_wdata),
        .raddr_a(raddr_a),
        .rdata_a(rdata_a),
        .raddr_b(j_reg),
        .rdata_b(rdata_b)
    );

    assign cmp_tag.valid = v1_reg;
    assign cmp_tag.idx   = tcf_pkg::TRACK_IDX_W'(j1_reg);

    tcf_pair_cmp u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cand_a   (rdata_a),
        .cand_b   (rdata_b),
        .threshold(thresh_reg),
        .tag      (cmp_tag),
        .res      (cmp_res)
    );

    assign last_j   = ((CNT_W'(j_reg) + CNT_W'(1)) == n_reg);
    assign last_i   = ((CNT_W'(i_reg) + CNT_W'(2)) == n_reg);
    assign n_minus1 = n_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        s_next         = s_reg;
        last_next      = last_reg;
        keep_next      = keep_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        out_end_next   = out_end_reg;

        if (cmp_res.valid && cmp_res.close)
        begin
            keep_next[cmp_res.idx[IDX_W-1:0]] = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_track)
                    begin
                        n_next    = room ? (count_reg + CNT_W'(1)) : count_reg;
                        i_next    = '0;
                        j_next    = IDX_W'(1);
                        s_next    = '0;
                        last_next = IDX_W'(n_next - CNT_W'(1));
                        state_next = (n_next == CNT_W'(1)) ? ST_LAST : ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (last_j && last_i)
                begin
                    state_next = ST_DRAIN;
                end
                else if (last_j)
                begin
                    i_next = i_reg + IDX_W'(1);
                    j_next = IDX_W'(CNT_W'(i_reg) + CNT_W'(2));
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !cmp_res.valid)
                begin
                    last_next  = IDX_W'(n_minus1);
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (keep_reg[last_reg])
                begin
                    s_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    last_next = last_reg - IDX_W'(1);
                end
            end
            ST_EMIT_RD:
            begin
                if (!keep_reg[s_reg])
                begin
                    s_next = s_reg + IDX_W'(1);
                end
                else if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_EMIT_WAIT;
                end
            end
            ST_EMIT_WAIT:
            begin
                out_valid_next = 1'b1;
                out_idx_next   = s_reg;
                out_data_next  = rdata_a;
                out_end_next   = (s_reg == last_reg);
                if (s_reg == last_reg)
                begin
                    count_next = '0;
                    keep_next  = '1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    s_next     = s_reg + IDX_W'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            s_reg         <= '0;
            last_reg      <= '0;
            keep_reg      <= '1;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            s_reg         <= s_next;
            last_reg      <= last_next;
            keep_reg      <= keep_next;
            v1_reg        <= (state_reg == ST_CMP);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j1_reg       <= j_reg;
        out_idx_reg  <= out_idx_next;
        out_data_reg <= out_data_next;
        out_end_reg  <= out_end_next;
    end

    assign out_valid    = out_valid_reg;
    assign track_index  = tcf_pkg::TRACK_IDX_W'(out_idx_reg);
    assign out_center_x = out_data_reg.x;
    assign out_center_y = out_data_reg.y;
    assign out_radius   = out_data_reg.r;
    assign run_end      = out_end_reg;

`ifndef SYNTH
    // the first entry of a batch can never be marked a clone
    a_keep_first: assert property (@(posedge clk) disable iff (!rst_n)
        keep_reg[0])
        else $error("entry 0 marked as clone");

    // no comparison in flight while loading
    a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!v1_reg && !cmp_res.valid))
        else $error("compare pipeline busy during load");

    // table fill never exceeds capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count above capacity");

    // a survivor is only loaded into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_WAIT) |-> $past(!out_valid_reg || out_ready))
        else $error("output register overwritten");
`endif

endmodule
`default_nettype wire

FILE: rtl/tcf_track_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_track_mem
// Candidate table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tcf_track_mem #(
    parameter int DEPTH  = tcf_pkg::MAX_TRACKS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire tcf_pkg::track_t   wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    output tcf_pkg::track_t        rdata_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output tcf_pkg::track_t        rdata_b
);

    tcf_pkg::track_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

FILE: rtl/tcf_pair_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_pair_cmp
// Registered closeness test of two candidates against the threshold.
// ----------------------------------------------------------------------------
module tcf_pair_cmp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tcf_pkg::track_t                  cand_a,
    input  wire tcf_pkg::track_t                  cand_b,
    input  wire logic [tcf_pkg::THRESH_W-1:0]     threshold,
    input  wire tcf_pkg::cmp_tag_t                tag,
    output tcf_pkg::cmp_res_t                     res
);

    logic [tcf_pkg::COORD_W-1:0] dx;
    logic [tcf_pkg::COORD_W-1:0] dy;
    logic [tcf_pkg::COORD_W-1:0] dr;
    logic [tcf_pkg::COORD_W-1:0] th;
    logic                        close;
    tcf_pkg::cmp_res_t           res_reg;
    tcf_pkg::cmp_res_t           res_next;

    always_comb
    begin
        dx = tcf_pkg::abs_diff({cand_a.x[tcf_pkg::COORD_W-1], cand_a.x},
                               {cand_b.x[tcf_pkg::COORD_W-1], cand_b.x});
        dy = tcf_pkg::abs_diff({cand_a.y[tcf_pkg::COORD_W-1], cand_a.y},
                               {cand_b.y[tcf_pkg::COORD_W-1], cand_b.y});
        dr = tcf_pkg::abs_diff({1'b0, cand_a.r}, {1'b0, cand_b.r});
        th = tcf_pkg::COORD_W'(threshold);
        close = (dx < th) && (dy < th) && (dr < th);
        res_next.valid = tag.valid;
        res_next.close = close;
        res_next.idx   = tag.idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire
